@@ hw/rtl/bvd_pkg.sv @@
package bvd_pkg;

   localparam int DataW = 32;
   localparam int CsrAddrW = 3;

   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_ACK    = 2'd1;
   localparam logic [1:0] ACT_FORCE  = 2'd2;

   localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
   localparam logic [1:0] DIR_FORWARD  = 2'd1;
   localparam logic [1:0] DIR_BACKWARD = 2'd2;

   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_FIRST_COMP = 1'b1;

   typedef struct packed {
      logic [1:0]             action;
      logic signed [DataW-1:0] counter_value;
      logic [1:0]             direction;
   } req_type;

   typedef struct packed {
      logic             backflow_flag;
      logic             backflow_active;
      logic [DataW-1:0] backflow_volume;
      logic [DataW-1:0] total_reverse_pulses;
   } rsp_type;

   typedef struct packed {
      logic [DataW-1:0] backflow_threshold;
      logic             first_pulse_compensation;
   } cfg_type;

endpackage

@@ hw/rtl/bvd_csr.sv @@
module bvd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bvd_pkg::CsrAddrW-1:0] paddr,
   input  logic [bvd_pkg::DataW-1:0]    pwdata,
   output logic [bvd_pkg::DataW-1:0]    prdata,
   output logic                         pready,
   output bvd_pkg::cfg_type             cfg
);
   import bvd_pkg::*;

   logic [DataW-1:0] threshold_ff;
   logic             comp_ff;
   logic             wr_en;
   logic             reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         comp_ff      <= 1'b0;
      end else if (wr_en) begin
         case (reg_sel)
            REG_THRESHOLD:  threshold_ff <= pwdata;
            REG_FIRST_COMP: comp_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_THRESHOLD:  prdata = threshold_ff;
         REG_FIRST_COMP: prdata = {{(DataW-1){1'b0}}, comp_ff};
         default:        prdata = '0;
      endcase
   end

   assign cfg.backflow_threshold       = threshold_ff;
   assign cfg.first_pulse_compensation = comp_ff;

endmodule

@@ hw/rtl/bvd_engine.sv @@
module bvd_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  bvd_pkg::req_type item,
   input  bvd_pkg::cfg_type cfg,
   output bvd_pkg::rsp_type result
);
   import bvd_pkg::*;

   logic [1:0]       last_dir_ff, last_dir_in;
   logic [DataW-1:0] last_count_ff, last_count_in;
   logic [DataW-1:0] marker_ff, marker_in;
   logic [DataW-1:0] volume_ff, volume_in;
   logic [DataW-1:0] ack_vol_ff, ack_vol_in;
   logic [DataW-1:0] remainder_ff, remainder_in;
   logic [DataW-1:0] peak_ff, peak_in;
   logic [DataW-1:0] total_ff, total_in;
   logic             alarm_ff, alarm_in;
   logic             active_ff, active_in;

   logic [DataW-1:0] v;
   logic [DataW-1:0] run;
   logic [DataW-1:0] t;
   logic [DataW-1:0] since_ack;

   always_comb begin
      last_dir_in   = last_dir_ff;
      last_count_in = last_count_ff;
      marker_in     = marker_ff;
      volume_in     = volume_ff;
      ack_vol_in    = ack_vol_ff;
      remainder_in  = remainder_ff;
      peak_in       = peak_ff;
      total_in      = total_ff;
      alarm_in      = alarm_ff;
      active_in     = active_ff;
      v             = item.counter_value;
      run           = '0;
      t             = '0;
      since_ack     = '0;
      case (item.action)
         ACT_SAMPLE: begin
            if (last_dir_ff == DIR_UNKNOWN) begin
               if (item.direction == DIR_FORWARD) begin
                  last_dir_in   = DIR_BACKWARD;
                  last_count_in = v - DataW'(1);
                  marker_in     = v - DataW'(1);
               end else if (item.direction == DIR_BACKWARD) begin
                  last_dir_in   = DIR_FORWARD;
                  last_count_in = v + DataW'(1);
                  marker_in     = v + DataW'(1);
               end
            end
            if (item.direction == DIR_BACKWARD) begin
               if (last_dir_in == DIR_FORWARD) begin
                  last_dir_in = DIR_BACKWARD;
                  if (cfg.first_pulse_compensation) begin
                     marker_in = marker_in + DataW'(1);
                  end
               end
               run       = marker_in - v;
               volume_in = run + remainder_ff;
               if (peak_ff < run) begin
                  total_in = total_ff + (run - peak_ff);
                  peak_in  = run;
               end
               since_ack = volume_in - ack_vol_ff;
               if (since_ack >= cfg.backflow_threshold) begin
                  alarm_in  = 1'b1;
                  active_in = 1'b1;
               end
            end else if (item.direction == DIR_FORWARD) begin
               if (last_dir_in == DIR_BACKWARD) begin
                  peak_in     = '0;
                  last_dir_in = DIR_FORWARD;
                  active_in   = 1'b0;
               end
               if ($signed(v) > $signed(last_count_in)) begin
                  t = volume_ff - (v - last_count_in);
                  if (t[DataW-1] || t == '0) begin
                     t = '0;
                  end
                  volume_in    = t;
                  remainder_in = t;
                  ack_vol_in   = t;
               end
               marker_in = v;
            end
            last_count_in = v;
         end
         ACT_ACK: begin
            ack_vol_in = volume_ff;
            alarm_in   = 1'b0;
         end
         ACT_FORCE: begin
            alarm_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_dir_ff   <= DIR_UNKNOWN;
         last_count_ff <= '0;
         marker_ff     <= '0;
         volume_ff     <= '0;
         ack_vol_ff    <= '0;
         remainder_ff  <= '0;
         peak_ff       <= '0;
         total_ff      <= '0;
         alarm_ff      <= 1'b0;
         active_ff     <= 1'b0;
      end else if (advance) begin
         last_dir_ff   <= last_dir_in;
         last_count_ff <= last_count_in;
         marker_ff     <= marker_in;
         volume_ff     <= volume_in;
         ack_vol_ff    <= ack_vol_in;
         remainder_ff  <= remainder_in;
         peak_ff       <= peak_in;
         total_ff      <= total_in;
         alarm_ff      <= alarm_in;
         active_ff     <= active_in;
      end
   end

   assign result.backflow_flag        = alarm_in;
   assign result.backflow_active      = active_in;
   assign result.backflow_volume      = volume_in;
   assign result.total_reverse_pulses = total_in;

endmodule

@@ hw/rtl/backflow_volume_detector.sv @@
// Backflow volume detector: tracks reverse flow from a signed pulse counter.
// Requests arrive on the req_ channel (valid/ready) and carry an action, a
// counter reading and a direction. Every request produces exactly one result
// on the rsp_ channel with the alarm flag, the active flag, the unrecovered
// reverse volume and the running total of reverse pulses.
// A request is captured into an input register; once the output register is
// free, the state update is computed and written, together with the result,
// into the output register, which drives the rsp_ channel.
// The block takes one request per cycle while the receiver does not stall;
// the state update loop sets that rate. When the receiver stalls, the result
// register holds and the input register takes a request only while it is empty.
// The threshold and first-pulse compensation registers are written through
// the APB port and should only change while no request is in flight.
// Synchronous reset clears all tracking state, both registers and both
// pipeline stages; the block accepts requests in the first cycle after reset.
module backflow_volume_detector (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bvd_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bvd_pkg::rsp_type             rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bvd_pkg::CsrAddrW-1:0] paddr,
   input  logic [bvd_pkg::DataW-1:0]    pwdata,
   output logic [bvd_pkg::DataW-1:0]    prdata,
   output logic                         pready
);
   import bvd_pkg::*;

   cfg_type cfg;
   req_type in_ff;
   logic    in_valid_ff;
   rsp_type out_ff;
   logic    out_valid_ff;
   rsp_type next_rsp;
   logic    out_free;
   logic    advance;

   bvd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   bvd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (next_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= next_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // An acknowledge always reports a cleared alarm.
   a_ack_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.action == ACT_ACK |=> !out_ff.backflow_flag)
      else $error("acknowledge did not clear the alarm");

   // A forced alarm always reports the alarm set.
   a_force_sets: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.action == ACT_FORCE |=> out_ff.backflow_flag)
      else $error("forced alarm not reported");

   // A stalled result stays valid with its payload unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule
